### hw/rtl/clx_pkg.sv
// Shared types, constants and helper functions for the C-subset lexer.
// No dependencies; imported by clx_core, clx_fifo and c_subset_lexer_top.
`timescale 1ns / 1ps
`default_nettype none

package clx_pkg;

    localparam int CHAR_W  = 8;
    localparam int POS_W   = 16;
    localparam int KIND_W  = 3;
    localparam int KWIDX_W = 4;

    // Keyword matching looks at the first KW_BYTES bytes of an identifier.
    localparam int KW_BYTES = 6;
    localparam int KW_COUNT = 10;

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [CHAR_W-1:0] CHAR_NL = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        KIND_KEYWORD  = 3'd0,
        KIND_IDENT    = 3'd1,
        KIND_NUMBER   = 3'd2,
        KIND_OPERATOR = 3'd3,
        KIND_DELIM    = 3'd4,
        KIND_END      = 3'd5,
        KIND_UNKNOWN  = 3'd6
    } token_kind_t;

    typedef struct packed {
        token_kind_t          kind;
        logic [POS_W-1:0]     line;
        logic [POS_W-1:0]     column;
        logic [POS_W-1:0]     length;
        logic [KWIDX_W-1:0]   kw_index;
        logic [CHAR_W-1:0]    single_char;
        logic                 last;
    } token_t;

    // Up to two tokens per input byte, in emit order.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    typedef logic [KW_BYTES-1:0][CHAR_W-1:0] kw_buf_t;

    typedef struct packed {
        logic               hit;
        logic [KWIDX_W-1:0] idx;
    } kw_hit_t;

    localparam logic [CHAR_W-1:0] KW_CHARS [KW_COUNT][KW_BYTES] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n"},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00},
        '{"v", "o", "i", "d", 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd4, 3'd5, 3'd3, 3'd2, 3'd6, 3'd3, 3'd5, 3'd4, 3'd4
    };

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c inside {["a":"z"], ["A":"Z"], "_"});
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c inside {" ", [8'd9:8'd13]});
    endfunction

    function automatic logic is_operator(input logic [CHAR_W-1:0] c);
        return (c inside {"+", "-", "*", "/", "=", "<", ">"});
    endfunction

    function automatic logic is_delim(input logic [CHAR_W-1:0] c);
        return (c inside {"(", ")", "{", "}", ";", ","});
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == POS_MAX) ? v : v + 16'd1;
    endfunction

    // Buffer bytes past the identifier length are zero, so a full-width
    // compare plus a length check identifies the keyword. Lowest index wins.
    function automatic kw_hit_t kw_lookup(input kw_buf_t b, input logic [POS_W-1:0] n);
        kw_hit_t r;
        logic    eq;
        r = '0;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            eq = (n == POS_W'(KW_LEN[k]));
            for (int j = 0; j < KW_BYTES; j++) begin
                if (b[j] != KW_CHARS[k][j]) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                r.hit = 1'b1;
                r.idx = KWIDX_W'(k);
            end
        end
        return r;
    endfunction

endpackage : clx_pkg

`default_nettype wire

### hw/rtl/clx_core.sv
// Lexer state and token generation: one source byte in, up to two tokens out.
// Depends on clx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clx_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       item_valid,
    input  wire logic [clx_pkg::CHAR_W-1:0] char_byte,
    input  wire logic                       end_flag,
    output clx_pkg::push_t                  push
);
    import clx_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_IDENT  = 3'b010,
        MODE_NUMBER = 3'b100
    } scan_mode_t;

    scan_mode_t       mode_reg, mode_next;
    logic [POS_W-1:0] line_reg, line_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] start_col_reg, start_col_next;
    logic [POS_W-1:0] count_reg, count_next;
    kw_buf_t          buf_reg, buf_next;
    logic             finished_reg, finished_next;

    logic     end_item;
    logic     pend_valid;
    kw_hit_t  kw;
    token_t   pend_tok, end_tok, char_tok;
    logic     emit_char;

    assign end_item = end_flag || (char_byte == CHAR_NUL);
    assign kw       = kw_lookup(buf_reg, count_reg);

    always_comb begin
        pend_tok             = '0;
        pend_tok.line        = line_reg;
        pend_tok.column      = start_col_reg;
        pend_tok.length      = count_reg;
        case (mode_reg)
            MODE_IDENT: begin
                pend_valid        = 1'b1;
                pend_tok.kind     = kw.hit ? KIND_KEYWORD : KIND_IDENT;
                pend_tok.kw_index = kw.hit ? kw.idx : '0;
            end
            MODE_NUMBER: begin
                pend_valid    = 1'b1;
                pend_tok.kind = KIND_NUMBER;
            end
            default: begin
                pend_valid    = 1'b0;
                pend_tok.kind = KIND_IDENT;
            end
        endcase

        end_tok        = '0;
        end_tok.kind   = KIND_END;
        end_tok.line   = line_reg;
        end_tok.column = col_reg;

        char_tok             = '0;
        char_tok.line        = line_reg;
        char_tok.column      = col_reg;
        char_tok.length      = 16'd1;
        char_tok.single_char = char_byte;
        if (is_operator(char_byte)) begin
            char_tok.kind = KIND_OPERATOR;
        end else if (is_delim(char_byte)) begin
            char_tok.kind = KIND_DELIM;
        end else begin
            char_tok.kind = KIND_UNKNOWN;
        end
    end

    always_comb begin
        mode_next      = mode_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        start_col_next = start_col_reg;
        count_next     = count_reg;
        buf_next       = buf_reg;
        finished_next  = finished_reg;
        push           = '0;
        emit_char      = 1'b0;

        if (finished_reg) begin
            push.count = 2'd1;
            push.first = end_tok;
        end else if (end_item) begin
            finished_next = 1'b1;
            mode_next     = MODE_IDLE;
            if (pend_valid) begin
                push.count  = 2'd2;
                push.first  = pend_tok;
                push.second = end_tok;
            end else begin
                push.count = 2'd1;
                push.first = end_tok;
            end
        end else if ((mode_reg == MODE_IDENT && (is_letter(char_byte) || is_digit(char_byte)))
                  || (mode_reg == MODE_NUMBER && is_digit(char_byte))) begin
            for (int i = 0; i < KW_BYTES; i++) begin
                if (count_reg == POS_W'(i)) begin
                    buf_next[i] = char_byte;
                end
            end
            count_next = sat_inc(count_reg);
        end else begin
            mode_next = MODE_IDLE;
            if (is_space(char_byte)) begin
                emit_char = 1'b0;
            end else if (is_letter(char_byte) || is_digit(char_byte)) begin
                mode_next      = is_letter(char_byte) ? MODE_IDENT : MODE_NUMBER;
                start_col_next = col_reg;
                count_next     = 16'd1;
                buf_next       = '0;
                buf_next[0]    = char_byte;
            end else begin
                emit_char = 1'b1;
            end

            if (pend_valid && emit_char) begin
                push.count  = 2'd2;
                push.first  = pend_tok;
                push.second = char_tok;
            end else if (pend_valid) begin
                push.count = 2'd1;
                push.first = pend_tok;
            end else if (emit_char) begin
                push.count = 2'd1;
                push.first = char_tok;
            end
        end

        // Position advances for each non-end-marker byte until end of text
        if (!finished_reg && !end_item) begin
            if (char_byte == CHAR_NL) begin
                line_next = sat_inc(line_reg);
                col_next  = 16'd1;
            end else begin
                col_next = sat_inc(col_reg);
            end
        end

        if (push.count == 2'd2) begin
            push.second.last = 1'b1;
        end else begin
            push.first.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            line_reg      <= 16'd1;
            col_reg       <= 16'd1;
            start_col_reg <= '0;
            count_reg     <= '0;
            buf_reg       <= '0;
            finished_reg  <= 1'b0;
        end else if (item_valid) begin
            mode_reg      <= mode_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            start_col_reg <= start_col_next;
            count_reg     <= count_next;
            buf_reg       <= buf_next;
            finished_reg  <= finished_next;
        end
    end

endmodule : clx_core

`default_nettype wire

### hw/rtl/clx_fifo.sv
// Result queue: takes zero, one or two tokens per cycle, hands out one when out_ready is high.
// Depends on clx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clx_fifo (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push_en,
    input  wire clx_pkg::push_t push,
    output logic         room2,
    output logic         out_valid,
    input  wire logic    out_ready,
    output clx_pkg::token_t out_token
);
    import clx_pkg::*;

    token_t               mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]           n_push;
    logic                 pop;
    logic [OQ_PTR_W-1:0]  wr_ptr_p1;

    assign room2     = (cnt_reg <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_token = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = push_en ? push.count : 2'd0;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OQ_PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + OQ_CNT_W'(n_push) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (n_push == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule : clx_fifo

`default_nettype wire

### hw/rtl/c_subset_lexer_top.sv
// Top level of the C-subset lexer: input register, lexer core, result queue.
// Depends on clx_pkg, clx_core and clx_fifo.
//
//  channel  | direction | payload
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | one source byte, tlast = end of text
//  m_axis   | out       | one token, tuser = kind, tlast = last token of byte
//
// One byte per cycle is accepted unless stalled; it enters the input register
// and, once taken, the core updates line/column/token state and writes zero,
// one or two tokens into a four-entry result queue. The input stalls only
// when the queue has room for fewer than two tokens; the output drains one
// token per cycle with m_axis_tready high. Reset returns to line 1, column 1 with no pending token.
`timescale 1ns / 1ps
`default_nettype none

module c_subset_lexer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire logic        s_axis_tlast,   // end-of-text flag
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [15:0] token_line, [31:16] token_column,
                                             // [47:32] token_length, [51:48] keyword_index,
                                             // [59:52] single_char, [63:60] zero
    output logic [2:0]       m_axis_tuser,   // token_kind
    output logic             m_axis_tlast    // last_result
);
    import clx_pkg::*;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_end_reg;
    logic              room2;
    logic              consume;
    push_t             push;
    token_t            out_token;

    assign consume       = in_valid_reg && room2;
    assign s_axis_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_char_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
    end

    clx_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (consume),
        .char_byte  (in_char_reg),
        .end_flag   (in_end_reg),
        .push       (push)
    );

    clx_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (consume),
        .push      (push),
        .room2     (room2),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_token (out_token)
    );

    assign m_axis_tdata = {4'b0000, out_token.single_char, out_token.kw_index,
                           out_token.length, out_token.column, out_token.line};
    assign m_axis_tuser = out_token.kind;
    assign m_axis_tlast = out_token.last;

endmodule : c_subset_lexer_top

`default_nettype wire
